// ===== hw/rtl/pip_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants of the point-in-polygon test core.
// -----------------------------------------------------------------------------
package pip_pkg;

   localparam int COORD_W      = 32;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int PROD_W       = 2 * DIFF_W;
   localparam int TAG_W        = 16;
   localparam int FUNC_W       = 2;
   localparam int STATUS_W     = 2;
   localparam int STORED_W     = 5;
   localparam int MIN_VERTICES = 3;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_TAG = 2'd0;

   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FEW      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]         func;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic [TAG_W-1:0]          query_map_tag;
   } req_type;

   typedef struct packed {
      logic                  inside_res;
      logic [STATUS_W-1:0]   status;
      logic [STORED_W-1:0]   stored_vertices;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } vertex_type;

   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } edge_ctl_type;

   typedef struct packed {
      logic done;
      logic parity;
   } edge_res_type;

endpackage

// ===== hw/rtl/point_in_polygon_test_core.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// point_in_polygon_test_core
// Even-odd ray casting test of a point against one stored polygon.
// -----------------------------------------------------------------------------
//  channel | direction | handshake              | beat
//  req     | in        | req_valid / req_stall  | req_type (func, coord, tag)
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_type (inside, status, count)
//  csr     | in        | APB write/read         | area_map_tag at offset 0
//
//  Clear, append and rejected queries answer in the cycle after acceptance.
//  A full query makes N + 1 reads of the vertex RAM for N stored vertices,
//  one per cycle, then passes through a three-stage edge pipeline.
//  One item is in work at a time; the result register frees the input side.
//  Synchronous reset empties the polygon and clears the map tag.
// -----------------------------------------------------------------------------
module point_in_polygon_test_core
   import pip_pkg::*;
#(
   parameter int MAX_VERTICES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic             first_ff, first_in;
   logic [TAG_W-1:0] tag_ff;
   vertex_type       point_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             load_rsp;
   logic             inside_val;
   logic [STATUS_W-1:0] status_val;
   logic             wr_en;
   logic             load_point;
   logic [CW-1:0]    last_cnt;
   logic [AW-1:0]    last_idx;
   logic [AW-1:0]    rd_addr;
   logic [CW+4:0]    count_ext;
   edge_ctl_type     ctl;
   edge_res_type     res;
   vertex_type       rd_data;
   vertex_type       wr_data;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign last_cnt = count_ff - CW'(1);
   assign last_idx = last_cnt[AW-1:0];
   assign wr_data  = '{x: req_data.coord_x, y: req_data.coord_y};

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      addr_in    = addr_ff;
      first_in   = first_ff;
      load_rsp   = 1'b0;
      inside_val = 1'b0;
      status_val = ST_OK;
      wr_en      = 1'b0;
      load_point = 1'b0;
      ctl        = '0;
      rd_addr    = addr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               load_rsp = 1'b1;
               case (req_data.func)
                  FUNC_CLEAR: begin
                     count_in = '0;
                  end
                  FUNC_APPEND: begin
                     if (count_ff == CW'(MAX_VERTICES)) begin
                        status_val = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  FUNC_QUERY: begin
                     if (req_data.query_map_tag != tag_ff) begin
                        status_val = ST_MISMATCH;
                     end else if (count_ff < CW'(MIN_VERTICES)) begin
                        status_val = ST_FEW;
                     end else begin
                        load_rsp   = 1'b0;
                        load_point = 1'b1;
                        first_in   = 1'b1;
                        state_in   = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            ctl.vld   = 1'b1;
            ctl.first = first_ff;
            ctl.last  = !first_ff && (addr_ff == last_idx);
            if (first_ff) begin
               rd_addr  = last_idx;
               first_in = 1'b0;
               addr_in  = '0;
            end else if (ctl.last) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            if (res.done) begin
               load_rsp   = 1'b1;
               inside_val = res.parity;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign count_ext = (CW+5)'(count_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.inside_res      = inside_val;
         rsp_data_in.status          = status_val;
         rsp_data_in.stored_vertices = count_ext[STORED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         addr_ff      <= '0;
         first_ff     <= 1'b0;
         tag_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         addr_ff      <= addr_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && (csr_paddr == CSR_ADDR_TAG)) begin
            tag_ff <= csr_pwdata[TAG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (load_point) begin
         point_ff <= wr_data;
      end
   end

   pip_vertex_ram #(
      .DEPTH (MAX_VERTICES),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pip_edge_pipe u_edge (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .rd_data (rd_data),
      .point   (point_ff),
      .res     (res)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_ADDR_TAG) ?
                       {{(CSR_DATA_W-TAG_W){1'b0}}, tag_ff} : '0;

endmodule

// ===== hw/rtl/pip_vertex_ram.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pip_vertex_ram
// Vertex store: one write port, one read port, registered read data.
// -----------------------------------------------------------------------------
module pip_vertex_ram
   import pip_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  vertex_type    wr_data,
   input  logic [AW-1:0] rd_addr,
   output vertex_type    rd_data
);

   vertex_type mem [DEPTH];
   vertex_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/pip_edge_pipe.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pip_edge_pipe
// Edge crossing pipeline: differences, cross products, compare and parity.
// -----------------------------------------------------------------------------
module pip_edge_pipe
   import pip_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  edge_ctl_type ctl,
   input  vertex_type   rd_data,
   input  vertex_type   point,
   output edge_res_type res
);

   edge_ctl_type s1_ctl_ff;
   vertex_type   prev_ff;

   logic                      s1_cross;
   logic signed [DIFF_W-1:0]  s1_a;
   logic signed [DIFF_W-1:0]  s1_b;
   logic signed [DIFF_W-1:0]  s1_c;
   logic signed [DIFF_W-1:0]  s1_e;

   logic                      s2_vld_ff;
   logic                      s2_last_ff;
   logic                      s2_cross_ff;
   logic                      s2_dpos_ff;
   logic signed [DIFF_W-1:0]  s2_a_ff;
   logic signed [DIFF_W-1:0]  s2_b_ff;
   logic signed [DIFF_W-1:0]  s2_c_ff;
   logic signed [DIFF_W-1:0]  s2_e_ff;

   logic                      s3_vld_ff;
   logic                      s3_last_ff;
   logic                      s3_cross_ff;
   logic                      s3_dpos_ff;
   logic signed [PROD_W-1:0]  s3_lhs_ff;
   logic signed [PROD_W-1:0]  s3_rhs_ff;

   logic                      s3_hit;
   logic                      parity_ff;
   logic                      parity_in;

   // xi/yi from the read port, xj/yj from the previous vertex
   always_comb begin
      s1_cross = (rd_data.y > point.y) != (prev_ff.y > point.y);
      s1_a     = DIFF_W'(point.x) - DIFF_W'(rd_data.x);
      s1_b     = DIFF_W'(prev_ff.y) - DIFF_W'(rd_data.y);
      s1_c     = DIFF_W'(prev_ff.x) - DIFF_W'(rd_data.x);
      s1_e     = DIFF_W'(point.y) - DIFF_W'(rd_data.y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         parity_ff <= 1'b0;
      end else begin
         s1_ctl_ff <= ctl;
         s2_vld_ff <= s1_ctl_ff.vld && !s1_ctl_ff.first;
         s3_vld_ff <= s2_vld_ff;
         parity_ff <= parity_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ctl_ff.vld) begin
         prev_ff <= rd_data;
      end
      s2_last_ff  <= s1_ctl_ff.last;
      s2_cross_ff <= s1_cross;
      s2_dpos_ff  <= !s1_b[DIFF_W-1];
      s2_a_ff     <= s1_a;
      s2_b_ff     <= s1_b;
      s2_c_ff     <= s1_c;
      s2_e_ff     <= s1_e;
      s3_last_ff  <= s2_last_ff;
      s3_cross_ff <= s2_cross_ff;
      s3_dpos_ff  <= s2_dpos_ff;
      s3_lhs_ff   <= PROD_W'(s2_a_ff) * PROD_W'(s2_b_ff);
      s3_rhs_ff   <= PROD_W'(s2_c_ff) * PROD_W'(s2_e_ff);
   end

   always_comb begin
      s3_hit = s3_cross_ff && (s3_dpos_ff ? (s3_lhs_ff < s3_rhs_ff)
                                          : (s3_rhs_ff < s3_lhs_ff));
      parity_in = parity_ff;
      if (s1_ctl_ff.vld && s1_ctl_ff.first) begin
         parity_in = 1'b0;
      end else if (s3_vld_ff && s3_hit) begin
         parity_in = !parity_ff;
      end
   end

   assign res.done   = s3_vld_ff && s3_last_ff;
   assign res.parity = parity_ff ^ s3_hit;

endmodule

// ===== hw/rtl/pip_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pip_checker
// Port-level checks of the point-in-polygon test core.
// -----------------------------------------------------------------------------
module pip_checker
   import pip_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   a_inside_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.inside_res |-> rsp_data.status == ST_OK)
      else $error("inside reported with non-ok status");

   a_few_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FEW
      |-> rsp_data.stored_vertices < STORED_W'(MIN_VERTICES))
      else $error("too-few status with enough vertices");

   a_clear_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.func == FUNC_CLEAR
      |=> rsp_valid && rsp_data.stored_vertices == '0 && rsp_data.status == ST_OK
          && !rsp_data.inside_res)
      else $error("clear did not answer with an empty polygon");

endmodule

bind point_in_polygon_test_core pip_checker u_pip_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// testbench
// Self-checking regression of the point-in-polygon test core.
// A scoreboard class predicts each result beat from its own copy of the
// polygon and map tag. It uses the even-odd ray crossing with an exact
// cross-multiplied compare. Accepted result beats are checked in order.
// Stimulus is a short directed set at the coordinate extremes, then random
// polygons with queries around them, and some noise items. The map tag goes
// through several settings. Both channels stall and idle at random, and the
// receiver holds off once for a long stretch.
// -----------------------------------------------------------------------------
module testbench;
   import pip_pkg::*;

   localparam int POLY_DEPTH     = 16;
   localparam int PHASE_ITEMS    = 206;
   localparam int HOLD_CYCLES    = 300;
   localparam int HOLD_AT_RESULT = 150;
   localparam int DRAIN_CYCLES   = 24;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic [FUNC_W-1:0]  FUNC_UNUSED = 2'd3;
   localparam logic [COORD_W-1:0] COORD_MIN   = 32'h8000_0000;
   localparam logic [COORD_W-1:0] COORD_MAX   = 32'h7FFF_FFFF;

   class polygon_scoreboard;
      logic signed [COORD_W-1:0] vert_x [POLY_DEPTH];
      logic signed [COORD_W-1:0] vert_y [POLY_DEPTH];
      int unsigned               vert_count;
      logic [TAG_W-1:0]          map_tag;
      rsp_type                   expected_rsp [$];
      int unsigned               mismatch_count;
      int unsigned               result_count;

      function new();
         vert_count     = 0;
         map_tag        = '0;
         mismatch_count = 0;
         result_count   = 0;
      endfunction

      function void set_tag(logic [TAG_W-1:0] t);
         map_tag = t;
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      // even-odd crossing count of a ray toward +x, edges from last vertex on
      function logic ray_parity(logic signed [COORD_W-1:0] tx,
                                logic signed [COORD_W-1:0] ty);
         logic                     par;
         int unsigned              i, j;
         logic signed [COORD_W:0]  dxq, dxe, dyq, dy;
         logic signed [2*COORD_W+3:0] lhs, rhs;
         par = 1'b0;
         j   = vert_count - 1;
         for (i = 0; i < vert_count; i++) begin
            if ((vert_y[i] > ty) != (vert_y[j] > ty)) begin
               dy  = (COORD_W+1)'(vert_y[j]) - (COORD_W+1)'(vert_y[i]);
               dxq = (COORD_W+1)'(tx) - (COORD_W+1)'(vert_x[i]);
               dxe = (COORD_W+1)'(vert_x[j]) - (COORD_W+1)'(vert_x[i]);
               dyq = (COORD_W+1)'(ty) - (COORD_W+1)'(vert_y[i]);
               lhs = (2*COORD_W+4)'(dxq) * (2*COORD_W+4)'(dy);
               rhs = (2*COORD_W+4)'(dxe) * (2*COORD_W+4)'(dyq);
               if (dy > 0 ? (lhs < rhs) : (rhs < lhs))
                  par = ~par;
            end
            j = i;
         end
         return par;
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         e = '0;
         case (r.func)
            FUNC_CLEAR: begin
               vert_count = 0;
            end
            FUNC_APPEND: begin
               if (vert_count < POLY_DEPTH) begin
                  vert_x[vert_count] = r.coord_x;
                  vert_y[vert_count] = r.coord_y;
                  vert_count++;
               end else begin
                  e.status = ST_FULL;
               end
            end
            FUNC_QUERY: begin
               if (r.query_map_tag != map_tag)
                  e.status = ST_MISMATCH;
               else if (vert_count < MIN_VERTICES)
                  e.status = ST_FEW;
               else
                  e.inside_res = ray_parity(r.coord_x, r.coord_y);
            end
            default: ;
         endcase
         e.stored_vertices = STORED_W'(vert_count);
         expected_rsp.insert(expected_rsp.size(), e);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         result_count++;
         if (expected_rsp.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result beat inside=%b status=%0d stored=%0d",
                     $time, got.inside_res, got.status, got.stored_vertices);
            return;
         end
         e = expected_rsp.pop_front();
         if (got.inside_res !== e.inside_res || got.status !== e.status ||
             got.stored_vertices !== e.stored_vertices) begin
            mismatch_count++;
            $display("%0t: result mismatch expected inside=%b status=%0d stored=%0d",
                     $time, e.inside_res, e.status, e.stored_vertices);
            $display("%0t:                   actual inside=%b status=%0d stored=%0d",
                     $time, got.inside_res, got.status, got.stored_vertices);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   polygon_scoreboard sb;
   bit                calm_phase;
   bit                hold_done;
   int unsigned       quiet_cycles;

   point_in_polygon_test_core #(
      .MAX_VERTICES(POLY_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_data);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("point_in_polygon_test_core regression: fail");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off to back up the input
   initial begin
      rsp_stall = 1'b0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && sb.result_count >= HOLD_AT_RESULT) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= !calm_phase && ($urandom_range(99) < 7);
      end
   end

   function automatic req_type make_req(logic [FUNC_W-1:0] f, logic [COORD_W-1:0] x,
                                        logic [COORD_W-1:0] y, logic [TAG_W-1:0] t);
      req_type r;
      r.func          = f;
      r.coord_x       = x;
      r.coord_y       = y;
      r.query_map_tag = t;
      return r;
   endfunction

   // 0: coarse integer grid, 1: mid range, else any 32-bit value
   function automatic logic [COORD_W-1:0] rand_coord(int unsigned style);
      case (style)
         0:       return (int'($urandom_range(16)) - 8) * 65536;
         1:       return int'($urandom_range(2097152)) - 1048576;
         default: return $urandom;
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send_item(input req_type r);
      while (!calm_phase && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] wdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (wr) begin
         if (addr == CSR_ADDR_TAG)
            sb.set_tag(wdata[TAG_W-1:0]);
      end else if (csr_prdata !== CSR_DATA_W'(sb.map_tag)) begin
         sb.mismatch_count++;
         $display("%0t: tag readback expected %h actual %h",
                  $time, CSR_DATA_W'(sb.map_tag), csr_prdata);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic run_directed();
      int k;
      send_item(make_req(FUNC_QUERY, 32'd0, 32'd0, 16'h0000));
      send_item(make_req(FUNC_QUERY, 32'd0, 32'd0, 16'hFFFF));
      send_item(make_req(FUNC_UNUSED, $urandom, $urandom, TAG_W'($urandom)));
      send_item(make_req(FUNC_CLEAR, $urandom, $urandom, TAG_W'($urandom)));
      send_item(make_req(FUNC_APPEND, COORD_MIN, COORD_MIN, 16'hFFFF));
      send_item(make_req(FUNC_APPEND, COORD_MAX, COORD_MIN, 16'h0000));
      send_item(make_req(FUNC_APPEND, COORD_MAX, COORD_MAX, 16'hFFFF));
      send_item(make_req(FUNC_APPEND, COORD_MIN, COORD_MAX, 16'h0000));
      send_item(make_req(FUNC_QUERY, 32'd0, 32'd0, 16'h0000));
      send_item(make_req(FUNC_QUERY, COORD_MIN, 32'd0, 16'h0000));
      send_item(make_req(FUNC_QUERY, COORD_MAX, COORD_MAX, 16'h0000));
      send_item(make_req(FUNC_QUERY, 32'd0, COORD_MIN, 16'h0000));
      for (k = 0; k < POLY_DEPTH - 4; k++)
         send_item(make_req(FUNC_APPEND, $urandom, $urandom, TAG_W'($urandom)));
      send_item(make_req(FUNC_APPEND, COORD_MAX, COORD_MAX, 16'hFFFF));
      send_item(make_req(FUNC_QUERY, $urandom, $urandom, 16'h0000));
   endtask

   task automatic run_random(input int unsigned target);
      int unsigned               counted, nv, nq, style, k, pick;
      logic signed [COORD_W-1:0] px [20];
      logic signed [COORD_W-1:0] py [20];
      logic [COORD_W-1:0]        qx, qy;
      logic [TAG_W-1:0]          qtag;
      logic [FUNC_W-1:0]         f;
      counted = 0;
      while (counted < target) begin
         if ($urandom_range(99) < 82) begin
            style = $urandom_range(2);
            send_item(make_req(FUNC_CLEAR, $urandom, $urandom, TAG_W'($urandom)));
            pick = $urandom_range(99);
            if (pick < 5)       nv = $urandom_range(2);
            else if (pick < 65) nv = $urandom_range(8, 3);
            else if (pick < 90) nv = $urandom_range(16, 9);
            else                nv = $urandom_range(19, 17);
            for (k = 0; k < nv; k++) begin
               px[k] = rand_coord(style);
               py[k] = rand_coord(style);
               send_item(make_req(FUNC_APPEND, px[k], py[k], TAG_W'($urandom)));
            end
            nq = $urandom_range(12, 3);
            for (k = 0; k < nq; k++) begin
               pick = $urandom_range(99);
               if (nv > 0 && pick < 30) begin
                  qy = py[$urandom_range(nv - 1)];
                  qx = (pick < 15) ? px[$urandom_range(nv - 1)] : rand_coord(style);
               end else if (pick < 85) begin
                  qx = rand_coord(style);
                  qy = rand_coord(style);
               end else begin
                  qx = $urandom;
                  qy = $urandom;
               end
               qtag = ($urandom_range(99) < 88) ? sb.map_tag
                                                : TAG_W'($urandom_range(65535));
               send_item(make_req(FUNC_QUERY, qx, qy, qtag));
            end
            counted += 1 + nv + nq;
         end else begin
            f = FUNC_W'($urandom_range(3));
            send_item(make_req(f, $urandom, $urandom, TAG_W'($urandom)));
            if (f != FUNC_UNUSED)
               counted++;
         end
      end
   endtask

   initial begin
      logic [TAG_W-1:0] tag_plan [4];
      int               phase;
      sb          = new();
      calm_phase  = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      tag_plan[0] = 16'hFFFF;
      tag_plan[1] = TAG_W'($urandom_range(65535));
      tag_plan[2] = 16'h0000;
      tag_plan[3] = TAG_W'($urandom_range(65535));
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      csr_access(1'b0, CSR_ADDR_TAG, '0);
      run_directed();
      drain();
      for (phase = 0; phase < 4; phase++) begin
         csr_access(1'b1, CSR_ADDR_TAG, CSR_DATA_W'(tag_plan[phase]));
         csr_access(1'b0, CSR_ADDR_TAG, '0);
         calm_phase = (phase == 1);
         run_random(PHASE_ITEMS);
         drain();
      end
      if (sb.pending() != 0)
         $display("%0t: %0d expected result beats never arrived", $time, sb.pending());
      if (sb.mismatch_count == 0 && sb.pending() == 0)
         $display("point_in_polygon_test_core regression: pass");
      else
         $display("point_in_polygon_test_core regression: fail");
      $finish;
   end

endmodule
